// ----- sv/lsps_pkg.sv -----
// ----------------------------------------------------------------------------
// lsps_pkg
// Shared types and constants for the line sensor steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package lsps_pkg;

    // Action codes reported with every result.
    typedef enum logic [1:0] {
        ACT_PID        = 2'd0,
        ACT_SPIN_LEFT  = 2'd1,
        ACT_SPIN_RIGHT = 2'd2,
        ACT_FAST       = 2'd3
    } t_action;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GAIN_P      = 3'd0,
        CFG_GAIN_I      = 3'd1,
        CFG_GAIN_D      = 3'd2,
        CFG_LEFT_BASE   = 3'd3,
        CFG_RIGHT_BASE  = 3'd4,
        CFG_FULL_SPEED  = 3'd5
    } t_cfg_idx;

    localparam int PATTERN_W = 5;
    localparam int ERR_W     = 4;
    localparam int DUTY_W    = 8;
    localparam int SUM_W     = 16;
    localparam int CFG_IDX_W = 3;

    // Reset values of the configuration registers.
    localparam logic [DUTY_W-1:0] RST_GAIN_P     = 8'd38;
    localparam logic [DUTY_W-1:0] RST_GAIN_I     = 8'd0;
    localparam logic [DUTY_W-1:0] RST_GAIN_D     = 8'd10;
    localparam logic [DUTY_W-1:0] RST_LEFT_BASE  = 8'd130;
    localparam logic [DUTY_W-1:0] RST_RIGHT_BASE = 8'd130;
    localparam logic [DUTY_W-1:0] RST_FULL_SPEED = 8'd255;

    // Integral accumulator saturates symmetrically at this magnitude.
    localparam logic signed [SUM_W:0] SUM_LIMIT = 17'sd32767;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register file as seen by the back end.
    typedef struct packed {
        logic [DUTY_W-1:0] gain_p;
        logic [DUTY_W-1:0] gain_i;
        logic [DUTY_W-1:0] gain_d;
        logic [DUTY_W-1:0] left_base;
        logic [DUTY_W-1:0] right_base;
        logic [DUTY_W-1:0] full_speed;
    } t_cfg;

    // One classified sample travelling from the front to the back.
    typedef struct packed {
        t_action                  act;
        logic signed [ERR_W-1:0]  err;
    } t_item;

    localparam int ITEM_W = $bits(t_item);

endpackage

`default_nettype wire

// ----- sv/lsps_front.sv -----
// ----------------------------------------------------------------------------
// lsps_front
// Accepts sensor samples, decodes the position error and classifies the action.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_front (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire  [lsps_pkg::PATTERN_W-1:0]    i_sensor_pattern,
    input  wire                               i_q_full,
    output logic                              o_push,
    output lsps_pkg::t_item                   o_item
);
    import lsps_pkg::*;

    // Sensor patterns (1 means off the line), leftmost sensor in bit 4.
    localparam logic [PATTERN_W-1:0] PAT_ERR_M4   = 5'b01111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M3   = 5'b00111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M2   = 5'b10111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M1   = 5'b10011;
    localparam logic [PATTERN_W-1:0] PAT_CENTER   = 5'b11011;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P1   = 5'b11001;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P2   = 5'b11101;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P3   = 5'b11100;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P4   = 5'b11110;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_L_A = 5'b00011;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_L_B = 5'b00001;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_R_A = 5'b11000;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_R_B = 5'b10000;

    logic signed [ERR_W-1:0] r_held;
    logic signed [ERR_W-1:0] n_held;
    t_action                 w_act;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Map known patterns to an error; anything else keeps the held error.
    always_comb begin
        unique case (i_sensor_pattern)
            PAT_ERR_M4: n_held = -4'sd4;
            PAT_ERR_M3: n_held = -4'sd3;
            PAT_ERR_M2: n_held = -4'sd2;
            PAT_ERR_M1: n_held = -4'sd1;
            PAT_CENTER: n_held = 4'sd0;
            PAT_ERR_P1: n_held = 4'sd1;
            PAT_ERR_P2: n_held = 4'sd2;
            PAT_ERR_P3: n_held = 4'sd3;
            PAT_ERR_P4: n_held = 4'sd4;
            default:    n_held = r_held;
        endcase
    end

    // Spins and the centered run bypass the PID step.
    always_comb begin
        unique case (i_sensor_pattern) inside
            PAT_SPIN_L_A, PAT_SPIN_L_B: w_act = ACT_SPIN_LEFT;
            PAT_SPIN_R_A, PAT_SPIN_R_B: w_act = ACT_SPIN_RIGHT;
            PAT_CENTER:                 w_act = ACT_FAST;
            default:                    w_act = ACT_PID;
        endcase
    end

    assign o_item.act = w_act;
    assign o_item.err = n_held;

    // The held error advances with every accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (o_push) begin
            r_held <= n_held;
        end
    end

endmodule

`default_nettype wire

// ----- sv/lsps_queue.sv -----
// ----------------------------------------------------------------------------
// lsps_queue
// Small first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  lsps_pkg::t_item   i_item,
    output logic              o_full,
    output logic              o_valid,
    input  wire               i_pop,
    output lsps_pkg::t_item   o_item
);
    import lsps_pkg::*;

    t_item               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QPTR_W:0]     r_count;
    logic                w_do_pop;

    assign o_full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign w_do_pop = i_pop && o_valid;
    assign o_item   = r_mem[r_rd_ptr];

    // Storage is written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- sv/lsps_back.sv -----
// ----------------------------------------------------------------------------
// lsps_back
// PID datapath: integral and derivative update, products, sum and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module lsps_back (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  lsps_pkg::t_cfg                   i_cfg,
    input  wire                              i_q_valid,
    input  lsps_pkg::t_item                  i_q_item,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [lsps_pkg::DUTY_W-1:0]      o_left_forward,
    output logic [lsps_pkg::DUTY_W-1:0]      o_left_reverse,
    output logic [lsps_pkg::DUTY_W-1:0]      o_right_forward,
    output logic [lsps_pkg::DUTY_W-1:0]      o_right_reverse,
    output lsps_pkg::t_action                o_action,
    output logic signed [lsps_pkg::ERR_W-1:0] o_position_error
);
    import lsps_pkg::*;

    localparam int D_W    = ERR_W + 1;
    localparam int PP_W   = DUTY_W + 1 + ERR_W;
    localparam int PI_W   = DUTY_W + 1 + SUM_W;
    localparam int PD_W   = DUTY_W + 1 + D_W;
    localparam int PID_W  = PI_W + 1;
    localparam int MOT_W  = PID_W + 1;

    // Clamp a signed drive value to the duty range.
    function automatic logic [DUTY_W-1:0] clamp_duty(input logic signed [MOT_W-1:0] v);
        logic [DUTY_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > MOT_W'(signed'({1'b0, {DUTY_W{1'b1}}}))) begin
            res = '1;
        end else begin
            res = v[DUTY_W-1:0];
        end
        return res;
    endfunction

    // PID state.
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [ERR_W-1:0]  r_last;

    // Stage A: updated integral and derivative.
    logic                     r_a_valid;
    t_action                  r_a_act;
    logic signed [ERR_W-1:0]  r_a_err;
    logic signed [SUM_W-1:0]  r_a_sum;
    logic signed [D_W-1:0]    r_a_d;

    // Stage B: registered products.
    logic                     r_b_valid;
    t_action                  r_b_act;
    logic signed [ERR_W-1:0]  r_b_err;
    logic signed [PP_W-1:0]   r_b_p;
    logic signed [PI_W-1:0]   r_b_i;
    logic signed [PD_W-1:0]   r_b_d;

    // Stage C: output register.
    logic                     r_c_valid;
    logic [DUTY_W-1:0]        r_lf;
    logic [DUTY_W-1:0]        r_lr;
    logic [DUTY_W-1:0]        r_rf;
    logic [DUTY_W-1:0]        r_rr;
    t_action                  r_c_act;
    logic signed [ERR_W-1:0]  r_c_err;

    logic                     w_adv;
    logic                     w_take;
    logic signed [SUM_W:0]    w_sum_raw;
    logic signed [SUM_W-1:0]  w_sum_sat;
    logic signed [D_W-1:0]    w_d;
    logic signed [PP_W-1:0]   w_p;
    logic signed [PI_W-1:0]   w_i;
    logic signed [PD_W-1:0]   w_dd;
    logic signed [PID_W-1:0]  w_pid;
    logic signed [MOT_W-1:0]  w_left;
    logic signed [MOT_W-1:0]  w_right;
    logic [DUTY_W-1:0]        n_lf;
    logic [DUTY_W-1:0]        n_lr;
    logic [DUTY_W-1:0]        n_rf;
    logic [DUTY_W-1:0]        n_rr;

    // The whole pipeline moves when the output register is free or drained.
    assign w_adv   = !r_c_valid || i_out_ready;
    assign o_q_pop = w_adv;
    assign w_take  = w_adv && i_q_valid;

    // Integral with saturation and derivative against the last PID error.
    always_comb begin
        w_sum_raw = (SUM_W+1)'(r_sum) + (SUM_W+1)'(i_q_item.err);
        if (w_sum_raw > SUM_LIMIT) begin
            w_sum_sat = SUM_W'(SUM_LIMIT);
        end else if (w_sum_raw < -SUM_LIMIT) begin
            w_sum_sat = SUM_W'(-SUM_LIMIT);
        end else begin
            w_sum_sat = w_sum_raw[SUM_W-1:0];
        end
        w_d = D_W'(i_q_item.err) - D_W'(r_last);
    end

    // Products of the gains with the stage A terms.
    assign w_p  = $signed({1'b0, i_cfg.gain_p}) * r_a_err;
    assign w_i  = $signed({1'b0, i_cfg.gain_i}) * r_a_sum;
    assign w_dd = $signed({1'b0, i_cfg.gain_d}) * r_a_d;

    // PID sum and the two motor drives.
    assign w_pid   = PID_W'(r_b_p) + PID_W'(r_b_i) + PID_W'(r_b_d);
    assign w_left  = MOT_W'($signed({1'b0, i_cfg.left_base})) + MOT_W'(w_pid);
    assign w_right = MOT_W'($signed({1'b0, i_cfg.right_base})) - MOT_W'(w_pid);

    // Duty selection per action.
    always_comb begin
        n_lf = '0;
        n_lr = '0;
        n_rf = '0;
        n_rr = '0;
        case (r_b_act)
            ACT_SPIN_LEFT: begin
                n_lr = i_cfg.full_speed;
                n_rf = i_cfg.full_speed;
            end
            ACT_SPIN_RIGHT: begin
                n_lf = i_cfg.full_speed;
                n_rr = i_cfg.full_speed;
            end
            ACT_FAST: begin
                n_lf = i_cfg.full_speed;
                n_rf = i_cfg.full_speed;
            end
            default: begin
                n_lf = clamp_duty(w_left);
                n_rf = clamp_duty(w_right);
            end
        endcase
    end

    // PID state changes only for beats that run the PID step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_last <= '0;
        end else if (w_take && (i_q_item.act == ACT_PID)) begin
            r_sum  <= w_sum_sat;
            r_last <= i_q_item.err;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else if (w_adv) begin
            r_a_valid <= i_q_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // Pipeline payload.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_act <= i_q_item.act;
            r_a_err <= i_q_item.err;
            r_a_sum <= w_sum_sat;
            r_a_d   <= w_d;
            r_b_act <= r_a_act;
            r_b_err <= r_a_err;
            r_b_p   <= w_p;
            r_b_i   <= w_i;
            r_b_d   <= w_dd;
            r_c_act <= r_b_act;
            r_c_err <= r_b_err;
            r_lf    <= n_lf;
            r_lr    <= n_lr;
            r_rf    <= n_rf;
            r_rr    <= n_rr;
        end
    end

    assign o_out_valid      = r_c_valid;
    assign o_left_forward   = r_lf;
    assign o_left_reverse   = r_lr;
    assign o_right_forward  = r_rf;
    assign o_right_reverse  = r_rr;
    assign o_action         = r_c_act;
    assign o_position_error = r_c_err;

endmodule

`default_nettype wire

// ----- sv/line_sensor_pd_steering_top.sv -----
// ----------------------------------------------------------------------------
// line_sensor_pd_steering_top
// Steering for a five-sensor line follower: pattern decode, PID and duties.
//
// Input channel: one 5-bit sensor sample per beat (i_in_valid / o_in_ready).
// Output channel: one result per sample with four PWM duties, the action code
// and the held position error (o_out_valid / i_out_ready), in sample order.
// Configuration: write i_cfg_data to register i_cfg_idx while i_cfg_we is high;
// indexes above five are ignored. Write only while the block is idle.
// Throughput: one sample per cycle while the receiver keeps taking results. An
// accepted sample is written into the queue, then passes the stage A register
// (integral and derivative update), the stage B register (the three gain
// products) and the output register, which takes the sum, clamp and duties.
// A four-entry queue sits between the decoder and the PID pipeline, so the
// decoder keeps taking samples while the receiver stalls until it fills;
// a stall freezes the PID pipeline in place and nothing is lost.
// Reset (synchronous, active low) loads the register defaults and clears the
// held error, the last PID error, the integral and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module line_sensor_pd_steering_top (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_we,
    input  wire  [lsps_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire  [lsps_pkg::DUTY_W-1:0]         i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_ready,
    input  wire  [lsps_pkg::PATTERN_W-1:0]      i_sensor_pattern,
    output logic                                o_out_valid,
    input  wire                                 i_out_ready,
    output logic [lsps_pkg::DUTY_W-1:0]         o_left_forward,
    output logic [lsps_pkg::DUTY_W-1:0]         o_left_reverse,
    output logic [lsps_pkg::DUTY_W-1:0]         o_right_forward,
    output logic [lsps_pkg::DUTY_W-1:0]         o_right_reverse,
    output logic [1:0]                          o_action,
    output logic signed [lsps_pkg::ERR_W-1:0]   o_position_error
);
    import lsps_pkg::*;

    t_cfg    r_cfg;
    logic    w_q_full;
    logic    w_push;
    t_item   w_push_item;
    logic    w_q_valid;
    logic    w_q_pop;
    t_item   w_q_item;
    t_action w_action;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p     <= RST_GAIN_P;
            r_cfg.gain_i     <= RST_GAIN_I;
            r_cfg.gain_d     <= RST_GAIN_D;
            r_cfg.left_base  <= RST_LEFT_BASE;
            r_cfg.right_base <= RST_RIGHT_BASE;
            r_cfg.full_speed <= RST_FULL_SPEED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_GAIN_P:     r_cfg.gain_p     <= i_cfg_data;
                CFG_GAIN_I:     r_cfg.gain_i     <= i_cfg_data;
                CFG_GAIN_D:     r_cfg.gain_d     <= i_cfg_data;
                CFG_LEFT_BASE:  r_cfg.left_base  <= i_cfg_data;
                CFG_RIGHT_BASE: r_cfg.right_base <= i_cfg_data;
                CFG_FULL_SPEED: r_cfg.full_speed <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sample decode and classification.
    lsps_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sensor_pattern (i_sensor_pattern),
        .i_q_full         (w_q_full),
        .o_push           (w_push),
        .o_item           (w_push_item)
    );

    // Decoupling queue.
    lsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_item  (w_q_item)
    );

    // PID pipeline and output register.
    lsps_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_valid        (w_q_valid),
        .i_q_item         (w_q_item),
        .o_q_pop          (w_q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_forward   (o_left_forward),
        .o_left_reverse   (o_left_reverse),
        .o_right_forward  (o_right_forward),
        .o_right_reverse  (o_right_reverse),
        .o_action         (w_action),
        .o_position_error (o_position_error)
    );

    assign o_action = 2'(w_action);

endmodule

`default_nettype wire

// ----- tb/sv/tb_steer_pkg.sv -----
// ----------------------------------------------------------------------------
// tb_steer_pkg
// Sensor pattern names and the result scoreboard for the steering testbench.
// The scoreboard keeps its own copy of the registers, the held error, the last
// PID error and the integral, predicts one result per accepted sample and
// compares the block's results against those predictions in order.
// ----------------------------------------------------------------------------
package tb_steer_pkg;
    import lsps_pkg::*;

    // Sensor patterns, bit 4 leftmost; a 0 means that sensor sees the line.
    localparam logic [PATTERN_W-1:0] PAT_ERR_M4      = 5'b01111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M3      = 5'b00111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M2      = 5'b10111;
    localparam logic [PATTERN_W-1:0] PAT_ERR_M1      = 5'b10011;
    localparam logic [PATTERN_W-1:0] PAT_CENTER      = 5'b11011;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P1      = 5'b11001;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P2      = 5'b11101;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P3      = 5'b11100;
    localparam logic [PATTERN_W-1:0] PAT_ERR_P4      = 5'b11110;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_L_WIDE = 5'b00011;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_L_EDGE = 5'b00001;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_R_WIDE = 5'b11000;
    localparam logic [PATTERN_W-1:0] PAT_SPIN_R_EDGE = 5'b10000;
    localparam logic [PATTERN_W-1:0] PAT_ALL_LINE    = 5'b00000;
    localparam logic [PATTERN_W-1:0] PAT_NO_LINE     = 5'b11111;
    localparam logic [PATTERN_W-1:0] PAT_ODD_A       = 5'b01010;
    localparam logic [PATTERN_W-1:0] PAT_ODD_B       = 5'b10101;

    // Error patterns ordered from -4 to +4, and the four spin patterns.
    localparam logic [PATTERN_W-1:0] ERR_PATTERNS [9] = '{
        PAT_ERR_M4, PAT_ERR_M3, PAT_ERR_M2, PAT_ERR_M1, PAT_CENTER,
        PAT_ERR_P1, PAT_ERR_P2, PAT_ERR_P3, PAT_ERR_P4
    };
    localparam logic [PATTERN_W-1:0] SPIN_PATTERNS [4] = '{
        PAT_SPIN_L_WIDE, PAT_SPIN_L_EDGE, PAT_SPIN_R_WIDE, PAT_SPIN_R_EDGE
    };

    // Register indexes past the last register; the block drops these writes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;

    localparam int ACC_MAX      = 32767;
    localparam int DUTY_MAX     = 255;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DUTY_W-1:0]       left_fwd;
        logic [DUTY_W-1:0]       left_rev;
        logic [DUTY_W-1:0]       right_fwd;
        logic [DUTY_W-1:0]       right_rev;
        t_action                 act;
        logic signed [ERR_W-1:0] err;
    } steer_result_t;

    class steer_scoreboard;
        logic [DUTY_W-1:0]       gain_p, gain_i, gain_d;
        logic [DUTY_W-1:0]       left_base, right_base, full_speed;
        logic signed [ERR_W-1:0] held_err, last_pid_err;
        logic signed [SUM_W-1:0] err_sum;
        steer_result_t           expected_q[$];
        int                      err_count;

        function new();
            gain_p       = RST_GAIN_P;
            gain_i       = RST_GAIN_I;
            gain_d       = RST_GAIN_D;
            left_base    = RST_LEFT_BASE;
            right_base   = RST_RIGHT_BASE;
            full_speed   = RST_FULL_SPEED;
            held_err     = '0;
            last_pid_err = '0;
            err_sum      = '0;
            err_count    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [DUTY_W-1:0] data);
            case (idx)
                CFG_GAIN_P:     gain_p = data;
                CFG_GAIN_I:     gain_i = data;
                CFG_GAIN_D:     gain_d = data;
                CFG_LEFT_BASE:  left_base = data;
                CFG_RIGHT_BASE: right_base = data;
                CFG_FULL_SPEED: full_speed = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [DUTY_W-1:0] clamp_duty(int v);
            if (v < 0) return '0;
            if (v > DUTY_MAX) return DUTY_MAX[DUTY_W-1:0];
            return v[DUTY_W-1:0];
        endfunction

        // Predict the result of one accepted sample and update the PID state.
        function void note_sample(logic [PATTERN_W-1:0] pat);
            steer_result_t r;
            int acc;
            int pid;
            r = '0;
            case (pat)
                PAT_ERR_M4: held_err = -4'sd4;
                PAT_ERR_M3: held_err = -4'sd3;
                PAT_ERR_M2: held_err = -4'sd2;
                PAT_ERR_M1: held_err = -4'sd1;
                PAT_CENTER: held_err = 4'sd0;
                PAT_ERR_P1: held_err = 4'sd1;
                PAT_ERR_P2: held_err = 4'sd2;
                PAT_ERR_P3: held_err = 4'sd3;
                PAT_ERR_P4: held_err = 4'sd4;
                default: ;  // An unknown pattern keeps the held error.
            endcase

            if (pat == PAT_SPIN_L_WIDE || pat == PAT_SPIN_L_EDGE) begin
                r.act       = ACT_SPIN_LEFT;
                r.left_rev  = full_speed;
                r.right_fwd = full_speed;
            end else if (pat == PAT_SPIN_R_WIDE || pat == PAT_SPIN_R_EDGE) begin
                r.act       = ACT_SPIN_RIGHT;
                r.left_fwd  = full_speed;
                r.right_rev = full_speed;
            end else if (pat == PAT_CENTER) begin
                r.act       = ACT_FAST;
                r.left_fwd  = full_speed;
                r.right_fwd = full_speed;
            end else begin
                // PID step: the integral saturates symmetrically.
                acc = int'(err_sum) + int'(held_err);
                if (acc > ACC_MAX) acc = ACC_MAX;
                if (acc < -ACC_MAX) acc = -ACC_MAX;
                pid = int'(gain_p) * int'(held_err) + int'(gain_i) * acc
                    + int'(gain_d) * (int'(held_err) - int'(last_pid_err));
                err_sum      = acc[SUM_W-1:0];
                last_pid_err = held_err;
                r.act        = ACT_PID;
                r.left_fwd   = clamp_duty(int'(left_base) + pid);
                r.right_fwd  = clamp_duty(int'(right_base) - pid);
            end
            r.err = held_err;
            expected_q.push_back(r);
        endfunction

        function string show(steer_result_t r);
            return $sformatf("lf=%0d lr=%0d rf=%0d rr=%0d act=%0d err=%0d",
                             r.left_fwd, r.left_rev, r.right_fwd, r.right_rev,
                             r.act, r.err);
        endfunction

        function void log_error(string msg);
            err_count++;
            if (err_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
        endfunction

        // Compare one accepted result with the oldest prediction.
        function void check_result(steer_result_t got);
            steer_result_t want;
            if (expected_q.size() == 0) begin
                log_error($sformatf("unexpected result %s", show(got)));
                return;
            end
            want = expected_q.pop_front();
            if (got.left_fwd !== want.left_fwd || got.left_rev !== want.left_rev ||
                got.right_fwd !== want.right_fwd || got.right_rev !== want.right_rev ||
                got.act !== want.act || got.err !== want.err) begin
                log_error($sformatf("expected %s, got %s", show(want), show(got)));
            end
        endfunction
    endclass

endpackage

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for line_sensor_pd_steering_top.
// Drives sensor samples through a valid/ready channel with random sender and
// receiver idling, moves through several register settings between phases,
// and checks every result beat against the scoreboard's prediction. A final
// run at the outermost errors with a unit integral gain walks the integral up
// and back down.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lsps_pkg::*;
    import tb_steer_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int RESET_CYCLES     = 7;
    localparam int DRAIN_CYCLES     = 12;
    localparam int RANDOM_PHASES    = 9;
    localparam int RANDOM_PER_PHASE = 190;
    localparam int SOAK_UP          = 90;
    localparam int SOAK_DOWN        = 90;
    localparam int TIMEOUT_NS       = 10_000_000;

    // Samples with reset register values: every pattern class and the extremes.
    localparam logic [PATTERN_W-1:0] DIRECTED_PATTERNS [21] = '{
        PAT_ERR_M4, PAT_ERR_M3, PAT_ERR_M2, PAT_ERR_M1, PAT_CENTER,
        PAT_ERR_P1, PAT_ERR_P2, PAT_ERR_P3, PAT_ERR_P4,
        PAT_ALL_LINE, PAT_NO_LINE, PAT_ODD_A,
        PAT_SPIN_L_WIDE, PAT_SPIN_L_EDGE, PAT_SPIN_R_WIDE, PAT_SPIN_R_EDGE,
        PAT_ERR_M4, PAT_ERR_P4, PAT_ODD_B, PAT_CENTER, PAT_ERR_M2
    };

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx        = '0;
    logic [DUTY_W-1:0]     i_cfg_data       = '0;
    logic                  i_in_valid       = 1'b0;
    logic                  o_in_ready;
    logic [PATTERN_W-1:0]  i_sensor_pattern = '0;
    logic                  o_out_valid;
    logic                  i_out_ready      = 1'b0;
    logic [DUTY_W-1:0]     o_left_forward;
    logic [DUTY_W-1:0]     o_left_reverse;
    logic [DUTY_W-1:0]     o_right_forward;
    logic [DUTY_W-1:0]     o_right_reverse;
    logic [1:0]            o_action;
    logic signed [ERR_W-1:0] o_position_error;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    steer_scoreboard sb = new();

    line_sensor_pd_steering_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_sensor_pattern (i_sensor_pattern),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_left_forward   (o_left_forward),
        .o_left_reverse   (o_left_reverse),
        .o_right_forward  (o_right_forward),
        .o_right_reverse  (o_right_reverse),
        .o_action         (o_action),
        .o_position_error (o_position_error)
    );

    // Free-running clock.
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver: random back-pressure, and a check of every accepted result beat.
    always @(posedge i_clk) begin
        steer_result_t got;
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.left_fwd  = o_left_forward;
            got.left_rev  = o_left_reverse;
            got.right_fwd = o_right_forward;
            got.right_rev = o_right_reverse;
            got.act       = t_action'(o_action);
            got.err       = o_position_error;
            sb.check_result(got);
        end
    end

    // Send one sample beat, with random idle cycles ahead of it.
    task automatic send_sample(input logic [PATTERN_W-1:0] pat);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_sensor_pattern <= pat;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_sample(pat);
    endtask

    // Stop sending and wait until every predicted result has come back.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_beat(input logic [CFG_IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Write all six registers, plus the two unused indexes with junk data.
    task automatic load_config(input logic [DUTY_W-1:0] gp, gi, gd, lb, rb, fs);
        cfg_beat(CFG_GAIN_P, gp);
        cfg_beat(CFG_GAIN_I, gi);
        cfg_beat(CFG_GAIN_D, gd);
        cfg_beat(CFG_LEFT_BASE, lb);
        cfg_beat(CFG_RIGHT_BASE, rb);
        cfg_beat(CFG_FULL_SPEED, fs);
        cfg_beat(CFG_SPARE_6, 8'($urandom_range(255)));
        cfg_beat(CFG_SPARE_7, 8'($urandom_range(255)));
        i_cfg_we <= 1'b0;
    endtask

    // Mostly a drifting line position, with spins and arbitrary patterns mixed in.
    task automatic run_random(input int count);
        int pos;
        int roll;
        logic [PATTERN_W-1:0] pat;
        pos = 0;
        repeat (count) begin
            roll = $urandom_range(99);
            if (roll < 65) begin
                pos = pos + int'($urandom_range(2)) - 1;
                if (pos > 4) pos = 4;
                if (pos < -4) pos = -4;
                pat = ERR_PATTERNS[pos + 4];
            end else if (roll < 75) begin
                pat = SPIN_PATTERNS[2'($urandom_range(3))];
            end else begin
                pat = 5'($urandom_range(31));
            end
            send_sample(pat);
        end
    endtask

    // Main sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED_PATTERNS[k]) send_sample(DIRECTED_PATTERNS[k]);

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            case (phase)
                0: load_config(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D,
                               RST_LEFT_BASE, RST_RIGHT_BASE, RST_FULL_SPEED);
                1: load_config(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
                2: load_config(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
                4: load_config(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0);
                5: load_config(8'($urandom_range(255)), 8'($urandom_range(3)),
                               8'($urandom_range(255)), 8'($urandom_range(255)),
                               8'($urandom_range(255)), 8'($urandom_range(255)));
                6: load_config(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd128);
                default: load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)),
                                     8'($urandom_range(255)), 8'($urandom_range(255)));
            endcase
            if (phase < 3) begin
                send_idle_pct = 36;
                recv_idle_pct = 59;
            end else if (phase < 6) begin
                send_idle_pct = 59;
                recv_idle_pct = 36;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            run_random(RANDOM_PER_PHASE);
        end

        // Integral walk: climb with the outermost positive error, then run back
        // down with the outermost negative one. Unit integral gain shows the sum
        // on the duties.
        settle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_config(8'd0, 8'd1, 8'd0, 8'd128, 8'd128, 8'd255);
        repeat (SOAK_UP) send_sample(PAT_ERR_P4);
        repeat (SOAK_DOWN) send_sample(PAT_ERR_M4);

        settle();
        if (sb.err_count == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
